// ----- rtl/papc_pkg.sv -----
// Shared types and constants for the pointer acceleration curve block.
// No dependencies.
package papc_pkg;
    localparam int SPEED_W = 16;
    localparam int OUT_W   = 19;
    localparam int DIV_W   = 16;
    localparam int MODE_W  = 3;
    localparam int REG_IDX_W = 3;
    localparam int CFG_W   = 16;

    localparam logic [MODE_W-1:0] MODE_LINEAR     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MILD       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MODERATE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STRONG     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_AGGRESSIVE = 3'd5;

    localparam logic [REG_IDX_W-1:0] REG_CURVE_MODE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MILD_SQ    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MOD_SQ     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MOD_CB     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STR_SQ     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_STR_CB     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_AGG_SQ     = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_AGG_CB     = 3'd7;

    // work item handed from the classifier to the evaluator
    typedef struct packed {
        logic [SPEED_W-1:0] t;       // clamped speed
        logic [DIV_W-1:0]   dq;      // square divisor, nonzero
        logic [DIV_W-1:0]   dc;      // cube divisor, nonzero
        logic               use_sq;  // add t^2/dq
        logic               use_cb;  // add t^3/dc
        logic               use_t;   // add t
        logic [2:0]         mult;    // ceiling = mult * N
    } t_job;
endpackage

// ----- rtl/papc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on papc_pkg. Carries a side payload alongside the quotient.
module papc_div import papc_pkg::*; #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 16,
    parameter int TAG_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_vld,
    output logic [NUM_W-1:0] o_quo,
    output logic [TAG_W-1:0] o_tag
);
    logic [NUM_W-1:0] r_q   [1:NUM_W];
    logic [DEN_W-1:0] r_rem [1:NUM_W];
    logic [DEN_W-1:0] r_den [1:NUM_W];
    logic [TAG_W-1:0] r_tag [1:NUM_W];
    logic             r_v   [1:NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [NUM_W-1:0] w_q;
        logic [DEN_W-1:0] w_rem;
        logic [DEN_W-1:0] w_den;
        logic [TAG_W-1:0] w_tag;
        logic             w_v;
        logic [DEN_W:0]   w_try;
        logic [DEN_W:0]   w_diff;
        // stage inputs: the ports for the first stage, the previous stage otherwise
        if (s == 0) begin : g_in
            assign w_q   = i_num;
            assign w_rem = '0;
            assign w_den = i_den;
            assign w_tag = i_tag;
            assign w_v   = i_vld;
        end else begin : g_mid
            assign w_q   = r_q[s];
            assign w_rem = r_rem[s];
            assign w_den = r_den[s];
            assign w_tag = r_tag[s];
            assign w_v   = r_v[s];
        end
        assign w_try  = {w_rem, w_q[NUM_W-1]};
        assign w_diff = w_try - {1'b0, w_den};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= w_v;
            end
            if (i_en) begin
                r_den[s+1] <= w_den;
                r_tag[s+1] <= w_tag;
                if (!w_diff[DEN_W]) begin
                    r_rem[s+1] <= w_diff[DEN_W-1:0];
                    r_q[s+1]   <= {w_q[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= w_try[DEN_W-1:0];
                    r_q[s+1]   <= {w_q[NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_vld = r_v[NUM_W];
    assign o_quo = r_q[NUM_W];
    assign o_tag = r_tag[NUM_W];
endmodule

// ----- rtl/papc_front.sv -----
// Front end: clamps speed, decodes mode, picks divisors into a job.
// Depends on papc_pkg.
module papc_front import papc_pkg::*; #(
    parameter int SPEED_FULL_SCALE = 1000,
    parameter int FALLBACK_DIVISOR = 1000
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic [SPEED_W-1:0] i_speed,
    output t_job               o_job
);
    localparam logic [SPEED_W-1:0] FULL = SPEED_W'(SPEED_FULL_SCALE);
    localparam logic [DIV_W-1:0] FB_DIV =
        (FALLBACK_DIVISOR == 0) ? DIV_W'(1) : DIV_W'(FALLBACK_DIVISOR);

    logic [MODE_W-1:0] r_mode;
    logic [DIV_W-1:0]  r_div [1:7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LINEAR;
            for (int k = 1; k < 8; k++) r_div[k] <= DIV_W'(1000);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_CURVE_MODE) r_mode <= i_cfg_data[MODE_W-1:0];
            else r_div[i_cfg_idx] <= i_cfg_data;
        end
    end

    function automatic logic [DIV_W-1:0] nz(input logic [DIV_W-1:0] d);
        return (d == '0) ? DIV_W'(1) : d;
    endfunction

    always_comb begin
        o_job.t      = (i_speed > FULL) ? FULL : i_speed;
        o_job.dq     = FB_DIV;
        o_job.dc     = DIV_W'(1);
        o_job.use_sq = 1'b1;
        o_job.use_cb = 1'b0;
        o_job.use_t  = 1'b0;
        o_job.mult   = 3'd1;
        unique case (r_mode)
            MODE_LINEAR: begin
                o_job.use_sq = 1'b0;
                o_job.use_t  = 1'b1;
            end
            MODE_MILD: begin
                o_job.dq = nz(r_div[REG_MILD_SQ]);
                o_job.use_t = 1'b1;
                o_job.mult = 3'd2;
            end
            MODE_MODERATE: begin
                o_job.dq = nz(r_div[REG_MOD_SQ]);
                o_job.dc = nz(r_div[REG_MOD_CB]);
                o_job.use_t = 1'b1; o_job.use_cb = 1'b1; o_job.mult = 3'd3;
            end
            MODE_STRONG: begin
                o_job.dq = nz(r_div[REG_STR_SQ]);
                o_job.dc = nz(r_div[REG_STR_CB]);
                o_job.use_t = 1'b1; o_job.use_cb = 1'b1; o_job.mult = 3'd4;
            end
            MODE_AGGRESSIVE: begin
                o_job.dq = nz(r_div[REG_AGG_SQ]);
                o_job.dc = nz(r_div[REG_AGG_CB]);
                o_job.use_t = 1'b1; o_job.use_cb = 1'b1; o_job.mult = 3'd5;
            end
            default: ;
        endcase
    end
endmodule

// ----- rtl/papc_back.sv -----
// Back end: squares and cubes t, divides both in pipelined dividers, sums and clamps.
// Depends on papc_pkg and papc_div.
module papc_back import papc_pkg::*; #(
    parameter int SPEED_FULL_SCALE = 1000
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  t_job             i_job,
    output logic             o_vld,
    output logic [OUT_W-1:0] o_value
);
    localparam int SQ_W = 2*SPEED_W;
    localparam int CB_W = 3*SPEED_W;
    localparam int STAG_W = SPEED_W + 2;
    localparam int CTAG_W = 3;
    localparam logic [OUT_W+3:0] FULL = (OUT_W+4)'(SPEED_FULL_SCALE);
    localparam logic [OUT_W+3:0] CAP  = FULL * (OUT_W+4)'(5);

    // stage 1: square
    logic             r1_v;
    t_job             r1_job;
    logic [SQ_W-1:0]  r1_sq;
    // stage 2: cube
    logic             r2_v;
    t_job             r2_job;
    logic [SQ_W-1:0]  r2_sq;
    logic [CB_W-1:0]  r2_cb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_vld;
            r2_v <= r1_v;
        end
        if (i_en) begin
            r1_job <= i_job;
            r1_sq  <= i_job.t * i_job.t;
            r2_job <= r1_job;
            r2_sq  <= r1_sq;
            r2_cb  <= r1_sq * r1_job.t;
        end
    end

    // square divider carries t and term flags, cube divider carries the ceiling multiple
    logic [STAG_W-1:0] w_stag, w_stag_o;
    logic [CTAG_W-1:0] w_ctag_o;
    logic [CB_W-1:0]   w_qs, w_qc;
    logic              w_vs, w_vc;
    assign w_stag = {r2_job.t, r2_job.use_t, r2_job.use_sq};

    papc_div #(.NUM_W(CB_W), .DEN_W(DIV_W), .TAG_W(STAG_W)) u_div_sq (
        .i_clk, .i_rst_n, .i_en, .i_vld(r2_v),
        .i_num({{(CB_W-SQ_W){1'b0}}, r2_sq}), .i_den(r2_job.dq), .i_tag(w_stag),
        .o_vld(w_vs), .o_quo(w_qs), .o_tag(w_stag_o)
    );
    papc_div #(.NUM_W(CB_W), .DEN_W(DIV_W), .TAG_W(CTAG_W)) u_div_cb (
        .i_clk, .i_rst_n, .i_en, .i_vld(r2_v & r2_job.use_cb),
        .i_num(r2_cb), .i_den(r2_job.dc), .i_tag(r2_job.mult),
        .o_vld(w_vc), .o_quo(w_qc), .o_tag(w_ctag_o)
    );

    logic [SPEED_W-1:0] w_t;
    logic               w_ut, w_us;
    logic [2:0]         w_mult;
    assign w_t    = w_stag_o[STAG_W-1 -: SPEED_W];
    assign w_ut   = w_stag_o[1];
    assign w_us   = w_stag_o[0];
    assign w_mult = w_ctag_o;

    // stage after dividers: saturating sum into a narrow word
    logic [OUT_W+3:0] w_qs_s, w_qc_s, w_sum, w_ceil;
    logic             r3_v;
    logic [OUT_W+3:0] r3_sum, r3_ceil;
    always_comb begin
        w_qs_s = (w_qs > CB_W'(CAP)) ? CAP : w_qs[OUT_W+3:0];
        w_qc_s = !w_vc ? '0 :
                 (w_qc > CB_W'(CAP)) ? CAP : w_qc[OUT_W+3:0];
        w_sum  = (w_ut ? (OUT_W+4)'(w_t) : '0) + (w_us ? w_qs_s : '0) + w_qc_s;
        w_ceil = FULL * (OUT_W+4)'(w_mult);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (i_en) r3_v <= w_vs;
        if (i_en) begin
            r3_sum  <= w_sum;
            r3_ceil <= w_ceil;
        end
    end
    assign o_vld   = r3_v;
    assign o_value = (r3_sum > r3_ceil) ? r3_ceil[OUT_W-1:0] : r3_sum[OUT_W-1:0];
endmodule

// ----- rtl/pointer_accel_poly_curve_top.sv -----
// Top level of the pointer acceleration curve block.
// Depends on papc_pkg, papc_front, papc_back, papc_div.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+-------------------------
//   speed    | in        | i_push / o_full     | i_speed[15:0]
//   result   | out       | o_empty / i_pop     | o_curve_value[18:0]
//   config   | in        | i_cfg_we            | i_cfg_idx[2:0], i_cfg_data[15:0]
//
// A speed sample can enter every cycle while o_full is low, passing two multiply
// stages, 48 restoring-divider stages, one sum stage and the result head register.
// The back pipeline never stalls; a credit counter admits at most 64 transfers
// not yet popped, so the queue plus head always has room, and o_full rises
// only while 64 results are outstanding.
// Reset is synchronous; it clears valid bits, credits and pointers, sets the mode to linear and every divisor to 1000.
module pointer_accel_poly_curve_top import papc_pkg::*; #(
    parameter int SPEED_FULL_SCALE = 1000,
    parameter int FALLBACK_DIVISOR = 1000
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [SPEED_W-1:0]   i_speed,
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic [OUT_W-1:0]     o_curve_value,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    localparam int LAT   = 3*SPEED_W + 3;   // back pipeline depth
    localparam int DEPTH = 64;              // result queue, >= LAT + 1
    localparam int PW    = $clog2(DEPTH);

    t_job w_job;
    papc_front #(.SPEED_FULL_SCALE(SPEED_FULL_SCALE),
                 .FALLBACK_DIVISOR(FALLBACK_DIVISOR)) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_speed, .o_job(w_job)
    );

    // credit count: items in the pipeline plus results in the queue and head register
    logic [PW:0] r_credit;
    logic        w_acc, w_pop;
    assign o_full = (r_credit >= (PW+1)'(DEPTH));
    assign w_acc  = i_push && !o_full;
    assign w_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_credit <= '0;
        else r_credit <= r_credit + (PW+1)'(w_acc) - (PW+1)'(w_pop);
    end

    logic             w_bv;
    logic [OUT_W-1:0] w_bval;
    papc_back #(.SPEED_FULL_SCALE(SPEED_FULL_SCALE)) u_back (
        .i_clk, .i_rst_n, .i_en(1'b1), .i_vld(w_acc), .i_job(w_job),
        .o_vld(w_bv), .o_value(w_bval)
    );

    // result queue with a registered read into the head register;
    // a result bypasses the memory when the memory is empty and the head is free
    logic [OUT_W-1:0] r_mem [DEPTH];
    logic [PW:0]      r_wp, r_rp;
    logic             r_head_v;
    logic [OUT_W-1:0] r_head;
    logic             w_mem_empty, w_head_ld, w_mem_wr;
    assign w_mem_empty = (r_wp == r_rp);
    assign w_head_ld   = !r_head_v || w_pop;
    assign w_mem_wr    = w_bv && !(w_head_ld && w_mem_empty);

    always_ff @(posedge i_clk) begin
        if (w_mem_wr) r_mem[r_wp[PW-1:0]] <= w_bval;
        if (w_head_ld) begin
            if (!w_mem_empty) r_head <= r_mem[r_rp[PW-1:0]];
            else if (w_bv) r_head <= w_bval;
        end
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_head_v <= 1'b0;
        end else begin
            if (w_mem_wr) r_wp <= r_wp + 1'b1;
            if (w_head_ld && !w_mem_empty) r_rp <= r_rp + 1'b1;
            if (w_head_ld) r_head_v <= !w_mem_empty || w_bv;
        end
    end
    assign o_empty       = !r_head_v;
    assign o_curve_value = r_head;
endmodule
